[rtl/load_cell_frame_weigher_macros.svh]
`ifndef LOAD_CELL_FRAME_WEIGHER_MACROS_SVH
`define LOAD_CELL_FRAME_WEIGHER_MACROS_SVH

// Same-cycle check: cons must hold whenever ante holds.
`define LCFW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcfw check failed");

// Next-cycle check: cons must hold in the cycle after ante.
`define LCFW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcfw check failed");

`endif

[rtl/lcfw_pkg.sv]
package lcfw_pkg;

  localparam int CELL_COUNT_MAX = 8;
  localparam int NUM_ZERO_REGS  = 8;

  localparam logic [7:0] HEAD_BYTE = 8'h00;
  localparam logic [7:0] CR_BYTE   = 8'h0D;
  localparam logic [7:0] LF_BYTE   = 8'h0A;

  // x/100 = (x/4)/25; (x/4) < 2^24, so /25 is a multiply by ceil(2^29/25) and a shift
  localparam logic [24:0] RECIP_25    = 25'd21474837;
  localparam int          RECIP_SHIFT = 29;

  localparam logic [21:0] TOTAL_MAX = 22'h3FFFFF;

  typedef struct packed {
    logic [23:0] raw_count;
    logic [2:0]  cell_index;
    logic        frame_ok;
    logic        round_last;
    logic        round_clear;
  } frame_rec_t;

  typedef struct packed {
    logic       push;
    frame_rec_t rec;
  } fq_wr_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    frame_rec_t rec;
  } fq_rd_t;

  typedef struct packed {
    logic [18:0] cell_weight;
    logic        frame_bad;
    logic [21:0] round_total;
    logic        round_done;
    logic        round_bad;
  } result_t;

endpackage

[rtl/load_cell_frame_weigher.sv]
// channel  | handshake        | payload
// ---------+------------------+-----------------------------------------------
// input    | in_push/in_full  | in_rx_byte, in_cell_index, in_frame_first,
//          |                  | in_round_first, in_round_last
// result   | out_pop/out_empty| out_cell_weight, out_frame_bad, out_round_total,
//          |                  | out_round_done, out_round_bad
// config   | cfg_we           | cfg_addr (0..7 = cell zero count), cfg_wdata
//
// One byte item is taken per cycle while in_full is low; the sixth byte of a
// frame queues a frame record (four deep) for the weighing pipeline.
// A result reaches the out_ ports through the frame record queue and the
// stages tare subtract, times three, reciprocal multiply for /100, accumulate.
// The pipeline stalls only when the two-entry result queue is full; in_full
// rises only when the frame record queue is full.
// Synchronous reset clears control state and the zero counts; no clear pass.
`include "load_cell_frame_weigher_macros.svh"

module load_cell_frame_weigher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  input  logic [2:0]  in_cell_index,
  input  logic        in_frame_first,
  input  logic        in_round_first,
  input  logic        in_round_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [18:0] out_cell_weight,
  output logic        out_frame_bad,
  output logic [21:0] out_round_total,
  output logic        out_round_done,
  output logic        out_round_bad,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  lcfw_pkg::fq_wr_t  fq_wr;
  lcfw_pkg::fq_rd_t  fq_rd;
  lcfw_pkg::result_t res;
  logic              fq_pop;
  logic              accept;

  assign in_full = fq_rd.full;
  assign accept  = in_push && !in_full;

  lcfw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_rx_byte     (in_rx_byte),
    .in_cell_index  (in_cell_index),
    .in_frame_first (in_frame_first),
    .in_round_first (in_round_first),
    .in_round_last  (in_round_last),
    .fq_wr          (fq_wr)
  );

  lcfw_frame_q u_frame_q (
    .clk   (clk),
    .rst_n (rst_n),
    .fq_wr (fq_wr),
    .pop   (fq_pop),
    .fq_rd (fq_rd)
  );

  lcfw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fq_rd     (fq_rd),
    .fq_pop    (fq_pop),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res       (res)
  );

  assign out_cell_weight = res.cell_weight;
  assign out_frame_bad   = res.frame_bad;
  assign out_round_total = res.round_total;
  assign out_round_done  = res.round_done;
  assign out_round_bad   = res.round_bad;

  `LCFW_ASSERT_NOW(a_no_pop_empty, fq_rd.empty, !fq_pop)
  `LCFW_ASSERT_NOW(a_push_has_room, fq_wr.push, !fq_rd.full)
  `LCFW_ASSERT_NOW(a_bad_weighs_zero, !out_empty && out_frame_bad,
                   out_cell_weight == 19'd0 && out_round_bad)
  `LCFW_ASSERT_NOW(a_total_only_clean, !out_empty && out_round_total != 22'd0,
                   out_round_done && !out_round_bad)

endmodule

[rtl/lcfw_front.sv]
module lcfw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_rx_byte,
  input  logic [2:0]          in_cell_index,
  input  logic                in_frame_first,
  input  logic                in_round_first,
  input  logic                in_round_last,
  output lcfw_pkg::fq_wr_t    fq_wr
);

  localparam logic [2:0] POS_HEAD = 3'd0;
  localparam logic [2:0] POS_LOW  = 3'd1;
  localparam logic [2:0] POS_MID  = 3'd2;
  localparam logic [2:0] POS_HIGH = 3'd3;
  localparam logic [2:0] POS_CR   = 3'd4;
  localparam logic [2:0] POS_LF   = 3'd5;
  localparam logic [2:0] POS_IDLE = 3'd6;

  logic [2:0]  pos_r, pos_nxt;
  logic [23:0] raw_r, raw_nxt;
  logic        ok_r, ok_nxt;
  logic        clr_r, clr_nxt;
  logic [2:0]  slot;
  logic        ok_cur, clr_cur, cell_ok;

  assign cell_ok = {1'b0, in_cell_index} < 4'(lcfw_pkg::CELL_COUNT_MAX);

  always_comb begin
    pos_nxt = pos_r;
    raw_nxt = raw_r;
    ok_nxt  = ok_r;
    clr_nxt = clr_r;
    slot    = pos_r;
    ok_cur  = ok_r;
    clr_cur = clr_r;
    fq_wr.push                 = 1'b0;
    fq_wr.rec.raw_count        = raw_r;
    fq_wr.rec.cell_index       = in_cell_index;
    fq_wr.rec.frame_ok         = 1'b0;
    fq_wr.rec.round_last       = in_round_last;
    fq_wr.rec.round_clear      = clr_r;
    if (accept) begin
      if (in_frame_first) begin
        slot    = POS_HEAD;
        ok_cur  = 1'b1;
        raw_nxt = '0;
        if (in_round_first) clr_cur = 1'b1;
      end
      ok_nxt  = ok_cur;
      clr_nxt = clr_cur;
      case (slot)
        POS_HEAD: begin
          if (in_rx_byte != lcfw_pkg::HEAD_BYTE) ok_nxt = 1'b0;
          pos_nxt = POS_LOW;
        end
        POS_LOW: begin
          raw_nxt[7:0] = in_rx_byte;
          pos_nxt = POS_MID;
        end
        POS_MID: begin
          raw_nxt[15:8] = in_rx_byte;
          pos_nxt = POS_HIGH;
        end
        POS_HIGH: begin
          raw_nxt[23:16] = in_rx_byte;
          pos_nxt = POS_CR;
        end
        POS_CR: begin
          if (in_rx_byte != lcfw_pkg::CR_BYTE) ok_nxt = 1'b0;
          pos_nxt = POS_LF;
        end
        POS_LF: begin
          fq_wr.push            = 1'b1;
          fq_wr.rec.frame_ok    = ok_cur && cell_ok && (in_rx_byte == lcfw_pkg::LF_BYTE);
          fq_wr.rec.round_clear = clr_cur;
          clr_nxt = 1'b0;
          pos_nxt = POS_IDLE;
        end
        default: ; // stray byte between frames
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_IDLE;
      ok_r  <= 1'b1;
      clr_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ok_r  <= ok_nxt;
      clr_r <= clr_nxt;
    end
    raw_r <= raw_nxt;
  end

endmodule

[rtl/lcfw_frame_q.sv]
module lcfw_frame_q (
  input  logic               clk,
  input  logic               rst_n,
  input  lcfw_pkg::fq_wr_t   fq_wr,
  input  logic               pop,
  output lcfw_pkg::fq_rd_t   fq_rd
);

  lcfw_pkg::frame_rec_t mem_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign do_pop      = pop && (cnt_r != 3'd0);
  assign fq_rd.empty = (cnt_r == 3'd0);
  assign fq_rd.full  = (cnt_r == 3'd4);
  assign fq_rd.rec   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (fq_wr.push && !do_pop) cnt_nxt = cnt_r + 3'd1;
    if (!fq_wr.push && do_pop) cnt_nxt = cnt_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (fq_wr.push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 2'd1;
    end
    if (fq_wr.push) mem_r[wr_ptr_r] <= fq_wr.rec;
  end

endmodule

[rtl/lcfw_back.sv]
module lcfw_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [23:0]          cfg_wdata,
  input  lcfw_pkg::fq_rd_t     fq_rd,
  output logic                 fq_pop,
  input  logic                 res_pop,
  output logic                 res_empty,
  output lcfw_pkg::result_t    res
);

  logic [23:0] zc_r [lcfw_pkg::NUM_ZERO_REGS];

  // pipeline: s1 tared diff, s2 three quarters, s3 weight, then accumulate
  logic        adv;
  logic        v1_r, v2_r, v3_r;
  logic [23:0] d1_r;
  logic [23:0] n2_r;
  logic [18:0] w3_r;
  logic [2:0]  f1_r, f2_r, f3_r; // {frame_ok, round_last, round_clear}

  logic [23:0] zc_sel;
  logic [25:0] triple;
  logic [48:0] prod;

  logic [21:0] tot_r, tot_nxt, tot_base;
  logic        err_r, err_nxt, err_cur;
  logic [22:0] sum;
  logic [21:0] tot_cur;
  lcfw_pkg::result_t res_new;

  lcfw_pkg::result_t oq_mem_r [2];
  logic       oq_wr_r, oq_rd_r;
  logic [1:0] oq_cnt_r, oq_cnt_nxt;
  logic       oq_full, oq_push, oq_pop;

  assign oq_full = (oq_cnt_r == 2'd2);
  assign adv     = !oq_full;
  assign fq_pop  = adv && !fq_rd.empty;

  assign zc_sel = zc_r[fq_rd.rec.cell_index];
  assign triple = 26'(d1_r) + {1'b0, d1_r, 1'b0};
  assign prod   = 49'(n2_r) * 49'(lcfw_pkg::RECIP_25);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lcfw_pkg::NUM_ZERO_REGS; i++) zc_r[i] <= '0;
    end else if (cfg_we) begin
      zc_r[cfg_addr] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= fq_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (adv) begin
      if (fq_rd.rec.frame_ok && (fq_rd.rec.raw_count > zc_sel)) begin
        d1_r <= fq_rd.rec.raw_count - zc_sel;
      end else begin
        d1_r <= '0;
      end
      f1_r <= {fq_rd.rec.frame_ok, fq_rd.rec.round_last, fq_rd.rec.round_clear};
      n2_r <= triple[25:2];
      f2_r <= f1_r;
      w3_r <= prod[lcfw_pkg::RECIP_SHIFT +: 19];
      f3_r <= f2_r;
    end
  end

  always_comb begin
    tot_base = f3_r[0] ? '0 : tot_r;
    err_cur  = f3_r[0] ? 1'b0 : err_r;
    sum      = 23'(tot_base) + 23'(w3_r);
    tot_cur  = tot_base;
    if (f3_r[2]) begin
      tot_cur = sum[22] ? lcfw_pkg::TOTAL_MAX : sum[21:0];
    end else begin
      err_cur = 1'b1;
    end
    res_new.cell_weight = w3_r;
    res_new.frame_bad   = !f3_r[2];
    res_new.round_total = (f3_r[1] && !err_cur) ? tot_cur : '0;
    res_new.round_done  = f3_r[1];
    res_new.round_bad   = err_cur;
    oq_push = v3_r && adv;
    tot_nxt = tot_r;
    err_nxt = err_r;
    if (oq_push) begin
      tot_nxt = f3_r[1] ? '0 : tot_cur;
      err_nxt = f3_r[1] ? 1'b0 : err_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0;
      err_r <= 1'b0;
    end else begin
      tot_r <= tot_nxt;
      err_r <= err_nxt;
    end
  end

  // result queue doubles as the output register stage
  assign oq_pop    = res_pop && (oq_cnt_r != 2'd0);
  assign res_empty = (oq_cnt_r == 2'd0);
  assign res       = oq_mem_r[oq_rd_r];

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) oq_cnt_nxt = oq_cnt_r + 2'd1;
    if (!oq_push && oq_pop) oq_cnt_nxt = oq_cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (oq_push) oq_wr_r <= !oq_wr_r;
      if (oq_pop) oq_rd_r <= !oq_rd_r;
    end
    if (oq_push) oq_mem_r[oq_wr_r] <= res_new;
  end

endmodule
